[design/gro_pkg.sv]
`timescale 1ns / 1ps

package gro_pkg;

    // Default side of the square routing grid, in cells.
    localparam int GRID_SIDE_DEF = 64;

    // Width of one coordinate and of one grid limit register.
    localparam int COORD_W = 6;

    // Width of the result status code.
    localparam int STATUS_W = 3;

    // Configuration register indexes.
    localparam logic [0:0] CFG_GRID_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_GRID_HEIGHT = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_COLLIDE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOPATH  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DIAG    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd4;

    // Controller states.
    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_LOAD,
        S_WALK,
        S_CLEAR,
        S_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;       // latch the incoming request
        logic start;        // set up the walker and read the first bitmap row
        logic walk_step;    // test and mark one cell
        logic clear_write;  // zero one bitmap row
        logic finish;       // update route state and load the result register
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_clear;     // latched request is a clear command
        logic need_walk;    // latched vertex has cells to walk
        logic walk_done;    // this walk step is the last one
        logic clear_last;   // this clear write reaches the last row
        logic out_free;     // result register can take a new result
    } t_ctl_stat;

endpackage

[design/gro_ram.sv]
`timescale 1ns / 1ps

module gro_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/gro_ctrl.sv]
`timescale 1ns / 1ps

module gro_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  gro_pkg::t_ctl_stat i_stat,
    output gro_pkg::t_ctl_cmd  o_cmd
);

    import gro_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register; reset starts the bitmap sweep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (i_stat.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_s_axis_tvalid) n_state = S_LOAD;
            end
            S_LOAD: begin
                if (i_stat.is_clear)       n_state = S_CLEAR;
                else if (i_stat.need_walk) n_state = S_WALK;
                else                       n_state = S_FINISH;
            end
            S_WALK: begin
                if (i_stat.walk_done) n_state = S_FINISH;
            end
            S_CLEAR: begin
                if (i_stat.clear_last) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd           = '0;
        o_s_axis_tready = 1'b0;
        case (r_state)
            S_INIT: begin
                o_cmd.clear_write = 1'b1;
            end
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                o_cmd.accept    = i_s_axis_tvalid;
            end
            S_LOAD: begin
                o_cmd.start = 1'b1;
            end
            S_WALK: begin
                o_cmd.walk_step = 1'b1;
            end
            S_CLEAR: begin
                o_cmd.clear_write = 1'b1;
            end
            S_FINISH: begin
                o_cmd.finish = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // A walk ends only in the finishing state.
    a_walk_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |=> (r_state == S_WALK || r_state == S_FINISH))
        else $error("walk left for a state other than finish");

    // A clear request always runs the full sweep before its result.
    a_clear_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD && i_stat.is_clear) |=> (r_state == S_CLEAR))
        else $error("clear request skipped the bitmap sweep");

    // A new request is never taken while one is in progress.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state == S_LOAD))
        else $error("accepted request did not enter load");

endmodule

[design/gro_datapath.sv]
`timescale 1ns / 1ps

module gro_datapath #(
    parameter int GRID_SIDE = gro_pkg::GRID_SIDE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gro_pkg::t_ctl_cmd             i_cmd,
    output gro_pkg::t_ctl_stat            o_stat,
    input  logic                          i_cfg_we,
    input  logic [0:0]                    i_cfg_idx,
    input  logic [gro_pkg::COORD_W-1:0]   i_cfg_wdata,
    input  logic                          i_in_cmd,
    input  logic [gro_pkg::COORD_W-1:0]   i_in_x,
    input  logic [gro_pkg::COORD_W-1:0]   i_in_y,
    input  logic                          i_in_first,
    input  logic                          i_in_last,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [gro_pkg::STATUS_W-1:0]  o_out_status,
    output logic                          o_out_route_ok
);

    import gro_pkg::*;

    localparam int AW = $clog2(GRID_SIDE);
    localparam logic [8:0] SIDE_MAX = 9'(GRID_SIDE - 1);
    localparam logic [AW-1:0] ROW_LAST = AW'(GRID_SIDE - 1);

    // Route and path state.
    logic [COORD_W-1:0] r_px, r_py, n_px, n_py;
    logic [1:0]         r_vc, n_vc;
    logic               r_ab, n_ab;
    logic               r_rg, n_rg;
    logic [COORD_W-1:0] r_gw, r_gh;
    logic [AW-1:0]      r_clr_idx;
    logic               r_m_tvalid;

    // Latched request and walker.
    logic                r_cmd, r_first, r_last;
    logic [COORD_W-1:0]  r_x, r_y;
    logic [COORD_W-1:0]  r_cx, r_cy, n_cx, n_cy;
    logic [GRID_SIDE-1:0] r_row;
    logic                r_use_ram;
    logic                r_collide;
    logic [STATUS_W-1:0] r_m_status, n_status, base_status;
    logic                r_m_route;

    // Bitmap row port signals.
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [GRID_SIDE-1:0] ram_wdata, ram_rdata;
    logic [GRID_SIDE-1:0] row_cur, row_set;
    logic                 hit;

    // Decode of the latched vertex against the path state.
    logic       new_path, active, diag, same, range_bad, fin_err;
    logic [1:0] eff_vc, vc1;
    logic       eff_ab;

    assign new_path  = r_first | (r_vc == 2'd0);
    assign eff_vc    = new_path ? 2'd0 : r_vc;
    assign eff_ab    = new_path ? 1'b0 : r_ab;
    assign active    = (eff_vc != 2'd0) && !eff_ab;
    assign diag      = (r_x != r_px) && (r_y != r_py);
    assign same      = (r_x == r_px) && (r_y == r_py);
    assign range_bad = (r_x > r_gw) || (r_y > r_gh) ||
                       ({3'b000, r_x} > SIDE_MAX) || ({3'b000, r_y} > SIDE_MAX);
    assign vc1       = (eff_vc == 2'd2) ? 2'd2 : eff_vc + 2'd1;

    // Walker: the row in hand comes from the memory after a new row read,
    // otherwise from the copy updated on the last step.
    assign row_cur = r_use_ram ? ram_rdata : r_row;
    assign hit     = row_cur[AW'(r_cy)];

    always_comb begin
        row_set             = row_cur;
        row_set[AW'(r_cy)]  = 1'b1;
    end

    // Next cell: x moves first, then y.
    always_comb begin
        n_cx = r_cx;
        n_cy = r_cy;
        if (r_cx != r_x) begin
            n_cx = (r_cx < r_x) ? r_cx + 6'd1 : r_cx - 6'd1;
        end else begin
            n_cy = (r_cy < r_y) ? r_cy + 6'd1 : r_cy - 6'd1;
        end
    end

    // Bitmap ports: the clear sweep and the walker share the write port.
    assign ram_we    = i_cmd.clear_write | (i_cmd.walk_step & !hit);
    assign ram_waddr = i_cmd.clear_write ? r_clr_idx : AW'(r_cx);
    assign ram_wdata = i_cmd.clear_write ? '0 : row_set;
    assign ram_raddr = i_cmd.start ? AW'(r_px) : AW'(n_cx);

    gro_ram #(
        .WIDTH (GRID_SIDE),
        .DEPTH (GRID_SIDE)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Status of the vertex before the end-of-path check.
    always_comb begin
        base_status = ST_OK;
        if (range_bad) begin
            base_status = ST_RANGE;
        end else if (active) begin
            if (diag)           base_status = ST_DIAG;
            else if (r_collide) base_status = ST_COLLIDE;
        end
    end

    assign fin_err = (base_status != ST_OK);

    // Route state after this request.
    always_comb begin
        n_px     = r_px;
        n_py     = r_py;
        n_vc     = r_vc;
        n_ab     = r_ab;
        n_rg     = r_rg;
        n_status = ST_OK;
        if (!r_cmd) begin
            n_px = '0;
            n_py = '0;
            n_vc = 2'd0;
            n_ab = 1'b0;
            n_rg = 1'b1;
        end else begin
            n_status = base_status;
            n_rg     = r_rg & !fin_err;
            n_ab     = eff_ab | fin_err;
            n_vc     = vc1;
            if (!range_bad) begin
                n_px = r_x;
                n_py = r_y;
            end
            if (r_last) begin
                if (vc1 <= 2'd1) begin
                    n_rg = 1'b0;
                    if (base_status == ST_OK) n_status = ST_NOPATH;
                end
                n_vc = 2'd0;
                n_ab = 1'b0;
            end
        end
    end

    // Control state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px       <= '0;
            r_py       <= '0;
            r_vc       <= 2'd0;
            r_ab       <= 1'b0;
            r_rg       <= 1'b1;
            r_gw       <= 6'd63;
            r_gh       <= 6'd63;
            r_clr_idx  <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_GRID_WIDTH)  r_gw <= i_cfg_wdata;
                if (i_cfg_idx == CFG_GRID_HEIGHT) r_gh <= i_cfg_wdata;
            end
            if (i_cmd.finish) begin
                r_px <= n_px;
                r_py <= n_py;
                r_vc <= n_vc;
                r_ab <= n_ab;
                r_rg <= n_rg;
            end
            if (i_cmd.clear_write) begin
                r_clr_idx <= (r_clr_idx == ROW_LAST) ? '0 : r_clr_idx + 1'b1;
            end
            if (i_cmd.finish) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    // Request latch, walker and result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd   <= i_in_cmd;
            r_x     <= i_in_x;
            r_y     <= i_in_y;
            r_first <= i_in_first;
            r_last  <= i_in_last;
        end
        if (i_cmd.start) begin
            r_cx      <= r_px;
            r_cy      <= r_py;
            r_use_ram <= 1'b1;
            r_collide <= 1'b0;
        end else if (i_cmd.walk_step) begin
            r_cx      <= n_cx;
            r_cy      <= n_cy;
            r_row     <= row_set;
            r_use_ram <= (n_cx != r_cx);
            r_collide <= hit;
        end
        if (i_cmd.finish) begin
            r_m_status <= n_status;
            r_m_route  <= n_rg;
        end
    end

    assign o_stat.is_clear   = !r_cmd;
    assign o_stat.need_walk  = r_cmd && !range_bad && active && !diag && !same;
    assign o_stat.walk_done  = hit || ((n_cx == r_x) && (n_cy == r_y));
    assign o_stat.clear_last = (r_clr_idx == ROW_LAST);
    assign o_stat.out_free   = !r_m_tvalid || i_m_axis_tready;

    assign o_m_axis_tvalid = r_m_tvalid;
    assign o_out_status    = r_m_status;
    assign o_out_route_ok  = r_m_route;

    // The walker never stands on the target vertex.
    a_not_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.walk_step |-> ((r_cx != r_x) || (r_cy != r_y)))
        else $error("walker reached the target cell");

    // Every walked segment is straight.
    a_straight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.walk_step |-> ((r_cx == r_x) || (r_cy == r_y)))
        else $error("walker left a straight segment");

    // The route flag only comes back through a clear request.
    a_route_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_rg && !(i_cmd.finish && !r_cmd)) |=> !r_rg)
        else $error("route flag set without a clear");

    // A result is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && r_m_tvalid) |-> i_m_axis_tready)
        else $error("pending result overwritten");

endmodule

[design/grid_route_overlap_checker_unit.sv]
// A vertex request walks its segment from the previous vertex, one bitmap row read,
// tested and written back per cycle, over at most 63 cells; a clear request zeroes
// one row per cycle. A new request is taken only once the last result is loaded,
// and loading waits while an earlier result is still unread. Reset (synchronous,
// active low) zeroes the bitmap in a row-by-row sweep with no request taken;
// configuration writes are always taken.
`timescale 1ns / 1ps

module grid_route_overlap_checker_unit #(
    parameter int GRID_SIDE = gro_pkg::GRID_SIDE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration write port.
    input  logic                        i_cfg_we,
    input  logic [0:0]                  i_cfg_idx,
    input  logic [gro_pkg::COORD_W-1:0] i_cfg_wdata,
    // Request stream.
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [15:0]                 i_s_axis_tdata,  // vertex_x, vertex_y, zero pad
    input  logic [1:0]                  i_s_axis_tuser,  // cmd, path_first
    input  logic                        i_s_axis_tlast,  // path_last
    // Result stream.
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [7:0]                  o_m_axis_tdata   // status, route_ok, zero pad
);

    import gro_pkg::*;

    t_ctl_cmd            ctl_cmd;
    t_ctl_stat           ctl_stat;
    logic [STATUS_W-1:0] out_status;
    logic                out_route_ok;

    gro_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_stat          (ctl_stat),
        .o_cmd           (ctl_cmd)
    );

    gro_datapath #(
        .GRID_SIDE (GRID_SIDE)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (ctl_cmd),
        .o_stat          (ctl_stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_cmd        (i_s_axis_tuser[0]),
        .i_in_x          (i_s_axis_tdata[5:0]),
        .i_in_y          (i_s_axis_tdata[11:6]),
        .i_in_first      (i_s_axis_tuser[1]),
        .i_in_last       (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_out_status    (out_status),
        .o_out_route_ok  (out_route_ok)
    );

    assign o_m_axis_tdata = {4'b0000, out_route_ok, out_status};

endmodule

[bench/grid_route_overlap_checker_unit_tb.sv]
`timescale 1ns / 1ps

module grid_route_overlap_checker_unit_tb;

    import gro_pkg::*;

    // Request command codes carried in the low tuser bit.
    localparam logic CMD_CLEAR  = 1'b0;
    localparam logic CMD_VERTEX = 1'b1;

    localparam int RESET_CYCLES    = 10;
    localparam int SETTLE_CYCLES   = 6;
    localparam int DRAIN_CYCLES    = 120;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 296;

    // One entry of the stimulus feed: either a register write or a request.
    typedef struct {
        bit         is_cfg;
        logic [0:0] cfg_idx;
        bit [5:0]   cfg_val;
        logic       cmd;
        bit [5:0]   vx;
        bit [5:0]   vy;
        bit         first;
        bit         last;
        bit         calm;
    } t_feed_entry;

    // Fields of one result.
    typedef struct {
        logic [STATUS_W-1:0] status;
        logic                route_ok;
    } t_route_result;

    logic        i_clk;
    logic        i_rst_n   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [0:0]  cfg_idx   = CFG_GRID_WIDTH;
    logic [5:0]  cfg_wdata = '0;
    logic        req_valid = 1'b0;
    logic [15:0] req_data  = '0;
    logic [1:0]  req_user  = '0;
    logic        req_last  = 1'b0;
    logic        res_ready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [7:0]  m_tdata;

    t_feed_entry   vertex_feed[$];
    t_route_result expected_status[$];

    // Shadow of the block: grid limits, bitmap and path state.
    bit [5:0]    lim_x = 6'd63;
    bit [5:0]    lim_y = 6'd63;
    bit [4095:0] occupied = '0;
    bit [5:0]    last_x = '0;
    bit [5:0]    last_y = '0;
    int          seg_count = 0;
    bit          path_dead = 1'b0;
    bit          route_good = 1'b1;

    int n_sent = 0;
    int n_done = 0;
    int n_errors = 0;
    int n_queued = 0;
    int n_clears = 0;
    int n_cfg_writes = 0;
    int status_seen[8];
    int cycle_count = 0;
    bit calm_now = 1'b0;
    bit gen_calm = 1'b0;

    grid_route_overlap_checker_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (req_valid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (req_data),   // vertex_x, vertex_y, zero pad
        .i_s_axis_tuser  (req_user),   // cmd, path_first
        .i_s_axis_tlast  (req_last),   // path_last
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (res_ready),
        .o_m_axis_tdata  (m_tdata)     // status, route_ok, zero pad
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Apply one accepted request to the shadow state and queue its result.
    function automatic void predict_route_status(input t_feed_entry req);
        t_route_result res;
        bit [5:0]      cx;
        bit [5:0]      cy;
        res.status = ST_OK;
        if (req.cmd == CMD_CLEAR) begin
            occupied   = '0;
            route_good = 1'b1;
            seg_count  = 0;
            path_dead  = 1'b0;
            last_x     = '0;
            last_y     = '0;
            n_clears++;
        end else begin
            if (req.first || seg_count == 0) begin
                seg_count = 0;
                path_dead = 1'b0;
            end
            if (req.vx > lim_x || req.vy > lim_y) begin
                // Out of range: the previous vertex is kept.
                res.status = ST_RANGE;
                route_good = 1'b0;
                path_dead  = 1'b1;
            end else begin
                if (seg_count >= 1 && !path_dead) begin
                    if (req.vx != last_x && req.vy != last_y) begin
                        res.status = ST_DIAG;
                    end else begin
                        // Walk toward the new vertex, leaving the vertex itself unmarked.
                        cx = last_x;
                        cy = last_y;
                        while ((cx != req.vx || cy != req.vy) && res.status == ST_OK) begin
                            if (occupied[{cx, cy}]) begin
                                res.status = ST_COLLIDE;
                            end else begin
                                occupied[{cx, cy}] = 1'b1;
                                if (cx != req.vx)
                                    cx = (cx < req.vx) ? cx + 6'd1 : cx - 6'd1;
                                else
                                    cy = (cy < req.vy) ? cy + 6'd1 : cy - 6'd1;
                            end
                        end
                    end
                    if (res.status != ST_OK) begin
                        route_good = 1'b0;
                        path_dead  = 1'b1;
                    end
                end
                last_x = req.vx;
                last_y = req.vy;
            end
            if (seg_count < 2)
                seg_count++;
            if (req.last) begin
                // A path of one vertex or fewer is not a path.
                if (seg_count <= 1) begin
                    route_good = 1'b0;
                    if (res.status == ST_OK)
                        res.status = ST_NOPATH;
                end
                seg_count = 0;
                path_dead = 1'b0;
            end
        end
        res.route_ok = route_good;
        status_seen[res.status]++;
        expected_status.push_back(res);
    endfunction

    task automatic add_cfg(input logic [0:0] idx, input bit [5:0] val);
        t_feed_entry e;
        e = '{default: '0};
        e.is_cfg  = 1'b1;
        e.cfg_idx = idx;
        e.cfg_val = val;
        e.calm    = gen_calm;
        vertex_feed.push_back(e);
    endtask

    task automatic add_req(input logic cmd, input bit [5:0] x, input bit [5:0] y,
                           input bit first, input bit last);
        t_feed_entry e;
        e = '{default: '0};
        e.cmd   = cmd;
        e.vx    = x;
        e.vy    = y;
        e.first = first;
        e.last  = last;
        e.calm  = gen_calm;
        vertex_feed.push_back(e);
        n_queued++;
    endtask

    // A mostly well-formed rectilinear path, with an occasional bad vertex.
    task automatic add_path(input bit [5:0] gw, input bit [5:0] gh);
        int       n;
        int       k;
        int       r;
        bit [5:0] px;
        bit [5:0] py;
        bit [5:0] nx;
        bit [5:0] ny;
        n  = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 6);
        px = 6'($urandom_range(0, gw));
        py = 6'($urandom_range(0, gh));
        add_req(CMD_VERTEX, px, py, 1'b1, (n == 1) && ($urandom_range(0, 15) != 0));
        for (k = 1; k < n; k++) begin
            r  = $urandom_range(0, 23);
            nx = px;
            ny = py;
            if (r == 0) begin
                nx = 6'($urandom_range(0, gw));
                ny = 6'($urandom_range(0, gh));
            end else if (r == 1) begin
                nx = 6'($urandom_range(0, 63));
                ny = 6'($urandom_range(0, 63));
            end else if (r == 2) begin
                // Zero-length segment.
            end else if (r % 2 == 1) begin
                nx = 6'($urandom_range(0, gw));
            end else begin
                ny = 6'($urandom_range(0, gh));
            end
            add_req(CMD_VERTEX, nx, ny, r == 3,
                    (k == n - 1) && ($urandom_range(0, 15) != 0));
            if (nx <= gw && ny <= gh) begin
                px = nx;
                py = ny;
            end
        end
    endtask

    // Request driver: feeds the block from the stimulus queue.
    always @(posedge i_clk) begin : drive_requests
        t_feed_entry nxt;
        logic        valid_nxt;
        logic        we_nxt;
        int          gap_left;
        int          quiet;
        static t_feed_entry cur_req;
        if (!i_rst_n) begin
            req_valid <= 1'b0;
            cfg_we    <= 1'b0;
            gap_left = 0;
            quiet    = 0;
        end else begin
            valid_nxt = req_valid;
            we_nxt    = 1'b0;
            if (req_valid && s_tready) begin
                predict_route_status(cur_req);
                n_sent++;
                valid_nxt = 1'b0;
            end
            if (!valid_nxt) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (vertex_feed.size() > 0) begin
                    if (vertex_feed[0].is_cfg) begin
                        // Registers change only once every result is out.
                        if (n_done == n_sent)
                            quiet++;
                        else
                            quiet = 0;
                        if (quiet >= SETTLE_CYCLES) begin
                            nxt = vertex_feed.pop_front();
                            if (nxt.cfg_idx == CFG_GRID_WIDTH)
                                lim_x = nxt.cfg_val;
                            else
                                lim_y = nxt.cfg_val;
                            cfg_idx   <= nxt.cfg_idx;
                            cfg_wdata <= nxt.cfg_val;
                            we_nxt = 1'b1;
                            quiet  = 0;
                            n_cfg_writes++;
                        end
                    end else if (!vertex_feed[0].calm && $urandom_range(0, 5) == 0) begin
                        gap_left = $urandom_range(1, 14) - 1;
                    end else begin
                        nxt = vertex_feed.pop_front();
                        cur_req = nxt;
                        req_data <= {4'b0000, nxt.vy, nxt.vx};
                        req_user <= {nxt.first, nxt.cmd};
                        req_last <= nxt.last;
                        calm_now <= nxt.calm;
                        valid_nxt = 1'b1;
                    end
                end
            end
            req_valid <= valid_nxt;
            cfg_we    <= we_nxt;
        end
    end

    // Result monitor: checks each result against the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_route_result got;
        t_route_result want;
        int            stall_left;
        if (!i_rst_n) begin
            res_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && res_ready) begin
                got.status   = m_tdata[STATUS_W-1:0];
                got.route_ok = m_tdata[STATUS_W];
                if (expected_status.size() == 0) begin
                    $display("%0t: unexpected result: status=%0d route_ok=%0b",
                             $time, got.status, got.route_ok);
                    n_errors++;
                end else begin
                    want = expected_status.pop_front();
                    if (got.status !== want.status) begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, got.status);
                        n_errors++;
                    end
                    if (got.route_ok !== want.route_ok) begin
                        $display("%0t: route_ok mismatch: expected %0b, actual %0b",
                                 $time, want.route_ok, got.route_ok);
                        n_errors++;
                    end
                end
                n_done <= n_done + 1;
            end
            if (stall_left > 0) begin
                stall_left--;
                res_ready <= 1'b0;
            end else if (!calm_now && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 14) - 1;
                res_ready <= 1'b0;
            end else begin
                res_ready <= 1'b1;
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d requests sent, %0d results seen",
                     $time, cycle_count, n_sent, n_done);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Stimulus build, reset and end of run.
    initial begin : run_sequence
        int       ph;
        int       r;
        int       target;
        bit [5:0] gw;
        bit [5:0] gh;

        // Directed part at the full grid: long edges, collision, bad segments.
        add_cfg(CFG_GRID_WIDTH, 6'd63);
        add_cfg(CFG_GRID_HEIGHT, 6'd63);
        add_req(CMD_CLEAR, 6'd63, 6'd63, 1'b1, 1'b1);
        add_req(CMD_VERTEX, 6'd0, 6'd0, 1'b1, 1'b0);
        add_req(CMD_VERTEX, 6'd63, 6'd0, 1'b0, 1'b0);
        add_req(CMD_VERTEX, 6'd63, 6'd63, 1'b0, 1'b0);
        add_req(CMD_VERTEX, 6'd0, 6'd63, 1'b0, 1'b0);
        add_req(CMD_VERTEX, 6'd0, 6'd0, 1'b0, 1'b1);
        // Collision on the bottom row, then the rest of the path is dead.
        add_req(CMD_VERTEX, 6'd2, 6'd1, 1'b1, 1'b0);
        add_req(CMD_VERTEX, 6'd2, 6'd0, 1'b0, 1'b0);
        add_req(CMD_VERTEX, 6'd4, 6'd0, 1'b0, 1'b0);
        add_req(CMD_VERTEX, 6'd9, 6'd9, 1'b0, 1'b0);
        add_req(CMD_VERTEX, 6'd9, 6'd9, 1'b0, 1'b1);
        // Diagonal segment.
        add_req(CMD_VERTEX, 6'd20, 6'd20, 1'b1, 1'b0);
        add_req(CMD_VERTEX, 6'd21, 6'd21, 1'b0, 1'b1);
        // Zero-length segment, single-vertex path, implicit path start.
        add_req(CMD_VERTEX, 6'd30, 6'd30, 1'b1, 1'b0);
        add_req(CMD_VERTEX, 6'd30, 6'd30, 1'b0, 1'b1);
        add_req(CMD_VERTEX, 6'd40, 6'd40, 1'b1, 1'b1);
        add_req(CMD_VERTEX, 6'd41, 6'd41, 1'b0, 1'b0);
        add_req(CMD_VERTEX, 6'd41, 6'd45, 1'b0, 1'b1);
        // A second path_first in the middle restarts the path.
        add_req(CMD_VERTEX, 6'd50, 6'd50, 1'b1, 1'b0);
        add_req(CMD_VERTEX, 6'd50, 6'd52, 1'b1, 1'b0);
        add_req(CMD_VERTEX, 6'd50, 6'd55, 1'b0, 1'b1);
        // Smallest grid: collision with an old mark, then x and y out of range.
        add_cfg(CFG_GRID_WIDTH, 6'd1);
        add_cfg(CFG_GRID_HEIGHT, 6'd1);
        add_req(CMD_VERTEX, 6'd1, 6'd1, 1'b1, 1'b0);
        add_req(CMD_VERTEX, 6'd1, 6'd0, 1'b0, 1'b0);
        add_req(CMD_VERTEX, 6'd0, 6'd0, 1'b0, 1'b1);
        add_req(CMD_VERTEX, 6'd2, 6'd1, 1'b1, 1'b1);
        add_req(CMD_VERTEX, 6'd1, 6'd2, 1'b1, 1'b1);

        // Random phases over several grid sizes; the last one runs without idling.
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin gw = 6'd63; gh = 6'd1;  end
                1: begin gw = 6'd1;  gh = 6'd63; end
                2: begin gw = 6'd17; gh = 6'd40; end
                3: begin
                    gw = 6'($urandom_range(1, 63));
                    gh = 6'($urandom_range(1, 63));
                end
                4: begin
                    gw = 6'($urandom_range(1, 20));
                    gh = 6'($urandom_range(1, 20));
                end
                default: begin gw = 6'd63; gh = 6'd63; end
            endcase
            gen_calm = (ph == NUM_PHASES - 1);
            add_cfg(CFG_GRID_WIDTH, gw);
            add_cfg(CFG_GRID_HEIGHT, gh);
            add_req(CMD_CLEAR, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            target = n_queued + ITEMS_PER_PHASE;
            while (n_queued < target) begin
                r = $urandom_range(0, 29);
                if (r == 0) begin
                    add_req(CMD_CLEAR, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end else if (r <= 3) begin
                    // Noise: arbitrary fields.
                    add_req(($urandom_range(0, 7) == 0) ? CMD_CLEAR : CMD_VERTEX,
                            6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end else begin
                    add_path(gw, gh);
                end
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every request is taken and every result is back.
        do
            @(negedge i_clk);
        while (vertex_feed.size() != 0 || req_valid || n_done != n_sent);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_status.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_status.size());
            n_errors++;
        end
        $display("Checked %0d results from %0d requests (%0d clears) over %0d register writes.",
                 n_done, n_sent, n_clears, n_cfg_writes);
        $display("Status mix: ok %0d, collision %0d, no path %0d, diagonal %0d, range %0d.",
                 status_seen[ST_OK], status_seen[ST_COLLIDE], status_seen[ST_NOPATH],
                 status_seen[ST_DIAG], status_seen[ST_RANGE]);
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
design/gro_pkg.sv
design/gro_ram.sv
design/gro_ctrl.sv
design/gro_datapath.sv
design/grid_route_overlap_checker_unit.sv
bench/grid_route_overlap_checker_unit_tb.sv
